// ===== design/awls_pkg.sv =====
`default_nettype none
package awls_pkg;

  localparam int SampleW    = 16;
  localparam int CountW     = 16;
  localparam int IndexW     = 32;
  localparam int SumW       = 32;
  localparam int SquareW    = 47;
  localparam int RootInW    = 32;
  localparam int SqrtSteps  = RootInW / 2;
  localparam int StepW      = 6;

  localparam int QUEUE_DEPTH = 2;

  localparam logic [CountW-1:0]  WINDOW_RESET = 16'd48000;
  localparam logic [SampleW-1:0] MIN_RESET    = 16'hFFFF;
  localparam logic [StepW-1:0]   DIV_LAST     = 6'(SquareW - 1);
  localparam logic [StepW-1:0]   SQRT_LAST    = 6'(SqrtSteps - 1);
  localparam logic [RootInW-1:0] PROBE_INIT   = 32'h4000_0000;

  // one finished window as handed from the front to the back
  typedef struct packed {
    logic [IndexW-1:0]        index;
    logic [CountW-1:0]        count;
    logic [SampleW-1:0]       minimum;
    logic [SampleW-1:0]       maximum;
    logic signed [SumW-1:0]   sum;
    logic [SquareW-1:0]       squares;
  } window_t;

  typedef struct packed {
    logic full;
    logic empty;
  } queue_status_t;

endpackage
`default_nettype wire

// ===== design/awls_sample_if.sv =====
`default_nettype none
interface awls_sample_if;
  logic        valid;
  logic        ready;
  logic [15:0] sample;

  modport source (output valid, output sample, input ready);
  modport sink   (input valid, input sample, output ready);
endinterface
`default_nettype wire

// ===== design/awls_result_if.sv =====
`default_nettype none
interface awls_result_if;
  logic               valid;
  logic               ready;
  logic [31:0]        window_index;
  logic [15:0]        sample_count;
  logic [15:0]        minimum;
  logic [15:0]        maximum;
  logic [15:0]        span;
  logic signed [15:0] mean;
  logic [15:0]        rms;

  modport source (output valid, output window_index, output sample_count,
                  output minimum, output maximum, output span, output mean,
                  output rms, input ready);
  modport sink   (input valid, input window_index, input sample_count,
                  input minimum, input maximum, input span, input mean,
                  input rms, output ready);
endinterface
`default_nettype wire

// ===== design/awls_front.sv =====
`default_nettype none
module awls_front (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  cfg_write,
  input  wire logic [15:0]           cfg_data,
  awls_sample_if.sink                samples,
  input  wire awls_pkg::queue_status_t q_status,
  output logic                       push,
  output awls_pkg::window_t          push_data
);

  logic [awls_pkg::CountW-1:0]   window_length;
  logic [awls_pkg::SquareW-1:0]  square_acc;
  logic signed [awls_pkg::SumW-1:0] sum_acc;
  logic [awls_pkg::CountW-1:0]   count;
  logic [awls_pkg::SampleW-1:0]  run_min;
  logic [awls_pkg::SampleW-1:0]  run_max;
  logic [awls_pkg::IndexW-1:0]   window_count;

  logic                          accept;
  logic signed [15:0]            centred;
  logic [31:0]                   square;
  logic [awls_pkg::CountW-1:0]   limit;
  logic [awls_pkg::CountW-1:0]   count_next;
  logic [awls_pkg::SampleW-1:0]  min_next;
  logic [awls_pkg::SampleW-1:0]  max_next;
  logic signed [awls_pkg::SumW-1:0] sum_next;
  logic [awls_pkg::SquareW-1:0]  square_next;
  logic                          close;

  assign samples.ready = !q_status.full;
  assign accept        = samples.valid && samples.ready;

  // subtracting midscale is a flip of the top bit
  assign centred     = $signed({~samples.sample[15], samples.sample[14:0]});
  assign square      = 32'($signed(centred) * $signed(centred));
  assign limit       = (window_length == '0) ? 16'd1 : window_length;
  assign count_next  = count + 16'd1;
  assign min_next    = (samples.sample < run_min) ? samples.sample : run_min;
  assign max_next    = (samples.sample > run_max) ? samples.sample : run_max;
  assign sum_next    = sum_acc + 32'(centred);
  assign square_next = square_acc + {15'd0, square};
  assign close       = count_next >= limit;

  assign push              = accept && close;
  assign push_data.index   = window_count + 32'd1;
  assign push_data.count   = count_next;
  assign push_data.minimum = min_next;
  assign push_data.maximum = max_next;
  assign push_data.sum     = sum_next;
  assign push_data.squares = square_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      window_length <= awls_pkg::WINDOW_RESET;
      square_acc    <= '0;
      sum_acc       <= '0;
      count         <= '0;
      run_min       <= awls_pkg::MIN_RESET;
      run_max       <= '0;
      window_count  <= '0;
    end else begin
      if (cfg_write) begin
        window_length <= cfg_data;
      end
      if (accept) begin
        if (close) begin
          square_acc   <= '0;
          sum_acc      <= '0;
          count        <= '0;
          run_min      <= awls_pkg::MIN_RESET;
          run_max      <= '0;
          window_count <= window_count + 32'd1;
        end else begin
          square_acc <= square_next;
          sum_acc    <= sum_next;
          count      <= count_next;
          run_min    <= min_next;
          run_max    <= max_next;
        end
      end
    end
  end

endmodule
`default_nettype wire

// ===== design/awls_queue.sv =====
`default_nettype none
module awls_queue #(
  parameter int Depth = awls_pkg::QUEUE_DEPTH
) (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    push,
  input  wire awls_pkg::window_t       push_data,
  input  wire logic                    pop,
  output awls_pkg::window_t            pop_data,
  output awls_pkg::queue_status_t      status
);

  localparam int PtrW = $clog2(Depth);
  localparam int FillW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0]  PtrLast = PtrW'(Depth - 1);
  localparam logic [FillW-1:0] FillMax = FillW'(Depth);

  awls_pkg::window_t mem [Depth];
  logic [PtrW-1:0]  wr_ptr;
  logic [PtrW-1:0]  rd_ptr;
  logic [FillW-1:0] fill;

  assign status.full  = fill == FillMax;
  assign status.empty = fill == '0;

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
    if (pop) begin
      pop_data <= mem[rd_ptr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PtrLast) ? '0 : wr_ptr + PtrW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PtrLast) ? '0 : rd_ptr + PtrW'(1);
      end
      case ({push, pop})
        2'b10:   fill <= fill + FillW'(1);
        2'b01:   fill <= fill - FillW'(1);
        default: fill <= fill;
      endcase
    end
  end

endmodule
`default_nettype wire

// ===== design/awls_back.sv =====
`default_nettype none
module awls_back (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire awls_pkg::queue_status_t q_status,
  output logic                         pop,
  input  wire awls_pkg::window_t       pop_data,
  awls_result_if.source                results
);

  typedef enum logic [4:0] {
    IDLE = 5'b00001,
    LOAD = 5'b00010,
    DIV  = 5'b00100,
    SQRT = 5'b01000,
    DONE = 5'b10000
  } state_t;

  state_t state;
  state_t state_next;

  awls_pkg::window_t             win;
  logic                          negative;
  logic [awls_pkg::StepW-1:0]    step;
  logic [awls_pkg::SquareW-1:0]  num_sq;
  logic [awls_pkg::SquareW-1:0]  num_sm;
  logic [awls_pkg::CountW-1:0]   rem_sq;
  logic [awls_pkg::CountW-1:0]   rem_sm;
  logic [awls_pkg::RootInW-1:0]  value;
  logic [awls_pkg::RootInW-1:0]  root;
  logic [awls_pkg::RootInW-1:0]  probe;

  logic [awls_pkg::CountW:0]     trial_sq;
  logic [awls_pkg::CountW:0]     trial_sm;
  logic                          bit_sq;
  logic                          bit_sm;
  logic [awls_pkg::SumW-1:0]     magnitude;
  logic [awls_pkg::RootInW-1:0]  root_trial;
  logic [15:0]                   quotient;

  assign pop = (state == IDLE) && !q_status.empty;

  // one bit of both restoring divisions per cycle
  assign trial_sq = {rem_sq, num_sq[awls_pkg::SquareW-1]};
  assign trial_sm = {rem_sm, num_sm[awls_pkg::SquareW-1]};
  assign bit_sq   = trial_sq >= {1'b0, win.count};
  assign bit_sm   = trial_sm >= {1'b0, win.count};

  assign magnitude  = pop_data.sum[awls_pkg::SumW-1] ? 32'(-pop_data.sum)
                                                     : 32'(pop_data.sum);
  assign root_trial = root + probe;

  always_comb begin
    state_next = state;
    unique case (state)
      IDLE: if (!q_status.empty) state_next = LOAD;
      LOAD: state_next = DIV;
      DIV:  if (step == '0) state_next = SQRT;
      SQRT: if (step == '0) state_next = DONE;
      DONE: if (results.ready) state_next = IDLE;
      default: state_next = IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      LOAD: begin
        win      <= pop_data;
        negative <= pop_data.sum[awls_pkg::SumW-1];
        num_sq   <= pop_data.squares;
        num_sm   <= {15'd0, magnitude};
        rem_sq   <= '0;
        rem_sm   <= '0;
        step     <= awls_pkg::DIV_LAST;
      end
      DIV: begin
        rem_sq <= bit_sq ? 16'(trial_sq - {1'b0, win.count}) : trial_sq[15:0];
        rem_sm <= bit_sm ? 16'(trial_sm - {1'b0, win.count}) : trial_sm[15:0];
        num_sq <= {num_sq[awls_pkg::SquareW-2:0], bit_sq};
        num_sm <= {num_sm[awls_pkg::SquareW-2:0], bit_sm};
        if (step == '0) begin
          // mean square never exceeds 2^30, so the low word holds it
          value <= num_sq[awls_pkg::RootInW-2:0] == '0 && !bit_sq ? '0
                   : {num_sq[awls_pkg::RootInW-2:0], bit_sq};
          root  <= '0;
          probe <= awls_pkg::PROBE_INIT;
          step  <= awls_pkg::SQRT_LAST;
        end else begin
          step <= step - 6'd1;
        end
      end
      SQRT: begin
        if (value >= root_trial) begin
          value <= value - root_trial;
          root  <= (root >> 1) + probe;
        end else begin
          root  <= root >> 1;
        end
        probe <= probe >> 2;
        step  <= step - 6'd1;
      end
      default: ;
    endcase
  end

  assign quotient = num_sm[15:0];

  assign results.valid        = state == DONE;
  assign results.window_index = win.index;
  assign results.sample_count = win.count;
  assign results.minimum      = win.minimum;
  assign results.maximum      = win.maximum;
  assign results.span         = win.maximum - win.minimum;
  assign results.mean         = negative ? $signed(16'(-quotient)) : $signed(quotient);
  assign results.rms          = root[15:0];

endmodule
`default_nettype wire

// ===== design/audio_window_level_stats_top.sv =====
// windowed audio level meter: each accepted request carries one unsigned
// 16-bit sample (midscale 32768 is zero) and the front accumulates it in the
// same cycle, so samples stream in at one per clock. when the sample count
// reaches window_length (a value of 0 acts as 1) the front closes the window
// and puts its totals into a small queue, then clears for the next window.
// the back takes one window at a time from the queue and works through load,
// a one-bit-per-cycle restoring divider (mean and mean square in parallel),
// a digit-by-digit square root and hand-off, then holds the result until it
// is taken. sample input stalls only when the queue is full, i.e. when
// windows close faster than the back can finish them or results are not
// being drained. window_length may be written at any idle moment; it does
// not clear the running totals
`default_nettype none
module audio_window_level_stats_top #(
  parameter int QueueDepth = awls_pkg::QUEUE_DEPTH
) (
  input  wire logic        clk,
  input  wire logic        rst,
  // window length register
  input  wire logic        cfg_write,
  input  wire logic [15:0] cfg_data,
  // sample requests in, window results out
  awls_sample_if.sink      samples,
  awls_result_if.source    results
);

  // front to queue
  logic                    push;
  awls_pkg::window_t       push_data;
  // queue to back
  logic                    pop;
  awls_pkg::window_t       pop_data;
  awls_pkg::queue_status_t q_status;

  // accumulate min, max, sum and square sum per window
  awls_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_data  (cfg_data),
    .samples   (samples),
    .q_status  (q_status),
    .push      (push),
    .push_data (push_data)
  );

  // closed windows waiting for the divider and square root
  awls_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .pop_data  (pop_data),
    .status    (q_status)
  );

  // mean, mean square and rms, one window at a time
  awls_back u_back (
    .clk      (clk),
    .rst      (rst),
    .q_status (q_status),
    .pop      (pop),
    .pop_data (pop_data),
    .results  (results)
  );

endmodule
`default_nettype wire

// ===== bench/audio_window_level_stats_top_tb.sv =====
module audio_window_level_stats_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  // one finished window as the result channel presents it
  typedef struct packed {
    logic [31:0]        window_index;
    logic [15:0]        sample_count;
    logic [15:0]        minimum;
    logic [15:0]        maximum;
    logic [15:0]        span;
    logic signed [15:0] mean;
    logic [15:0]        rms;
  } level_stats_t;

  // sample styles for the request generator
  localparam int StyleMixed    = 0;
  localparam int StyleRailHeavy = 1;

  localparam logic [15:0] Midscale   = 16'd32768;
  localparam logic [15:0] LengthMax  = 16'hFFFF;
  // long enough for the back to finish a window still in flight
  localparam int SettleCycles = 100;

  logic clk;
  logic rst;
  logic cfg_write;
  logic [15:0] cfg_data;

  awls_sample_if sample_ch();
  awls_result_if result_ch();

  audio_window_level_stats_top DUT (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_data  (cfg_data),
    .samples   (sample_ch),
    .results   (result_ch)
  );

  // sample requests waiting for the driver, window stats waiting for the monitor
  logic [15:0]  samples_pending[$];
  level_stats_t stats_due[$];

  int send_idle_pct;
  int recv_stall_pct;
  int mismatch_count;
  logic sample_accepted;

  // shadow of the meter: running window totals and the length register
  logic [15:0]        window_length;
  logic [46:0]        square_total;
  logic signed [31:0] centred_sum;
  logic [15:0]        samples_in_window;
  logic [15:0]        lowest_sample;
  logic [15:0]        highest_sample;
  logic [31:0]        windows_closed;

  always #5 clk = ~clk;

  // floor square root, one result bit per pass from the top down
  function automatic logic [15:0] root_floor(longint unsigned value);
    logic [16:0] root;
    longint unsigned trial;
    root = '0;
    for (int b = 16; b >= 0; b--) begin
      trial = longint'(root | (17'd1 << b));
      if (trial * trial <= value) root = root | (17'd1 << b);
    end
    return root[15:0];
  endfunction

  function automatic void clear_window_totals();
    square_total      = '0;
    centred_sum       = '0;
    samples_in_window = '0;
    lowest_sample     = 16'hFFFF;
    highest_sample    = '0;
  endfunction

  // fold one accepted sample into the window; queue the stats when it closes
  task automatic accumulate_sample(input logic [15:0] raw);
    longint centred;
    longint unsigned limit;
    longint mean_full;
    longint unsigned mean_square;
    level_stats_t stats;
    centred = longint'(raw) - longint'(Midscale);
    if (raw < lowest_sample) lowest_sample = raw;
    if (raw > highest_sample) highest_sample = raw;
    centred_sum = centred_sum + 32'(centred);
    square_total = square_total + 47'(centred * centred);
    samples_in_window = samples_in_window + 16'd1;
    // a length of zero behaves as one
    limit = (window_length == 16'd0) ? 1 : longint'(window_length);
    // >= rather than == so a length lowered mid-window closes on the next sample
    if (longint'(samples_in_window) >= limit) begin
      windows_closed = windows_closed + 32'd1;
      mean_full = longint'(centred_sum) / longint'(samples_in_window);
      mean_square = longint'(square_total) / longint'(samples_in_window);
      stats.window_index = windows_closed;
      stats.sample_count = samples_in_window;
      stats.minimum      = lowest_sample;
      stats.maximum      = highest_sample;
      stats.span         = highest_sample - lowest_sample;
      stats.mean         = mean_full[15:0];
      stats.rms          = root_floor(mean_square);
      stats_due.push_back(stats);
      clear_window_totals();
    end
  endtask

  function automatic void check_field(string what, longint want, longint got);
    if (want != got) begin
      $display("%0t: %s expected %0d actual %0d", $time, what, want, got);
      mismatch_count++;
    end
  endfunction

  // request driver: hold a sample until taken, then maybe idle before the next
  always @(negedge clk) begin
    if (rst) begin
      sample_ch.valid <= 1'b0;
    end else if (!sample_ch.valid || sample_accepted) begin
      if (samples_pending.size() != 0 && $urandom_range(99, 0) >= send_idle_pct) begin
        sample_ch.valid  <= 1'b1;
        sample_ch.sample <= samples_pending.pop_front();
      end else begin
        sample_ch.valid <= 1'b0;
      end
    end
  end

  // result side backpressure
  always @(negedge clk) begin
    if (rst) begin
      result_ch.ready <= 1'b0;
    end else begin
      result_ch.ready <= ($urandom_range(99, 0) >= recv_stall_pct);
    end
  end

  // monitor: retire results first, then fold in the sample taken at this edge
  always @(posedge clk) begin
    level_stats_t want;
    if (rst) begin
      sample_accepted <= 1'b0;
    end else begin
      if (result_ch.valid && result_ch.ready) begin
        if (stats_due.size() == 0) begin
          $display("%0t: result with no window pending, index %0d count %0d",
                   $time, result_ch.window_index, result_ch.sample_count);
          mismatch_count++;
        end else begin
          want = stats_due.pop_front();
          check_field("window_index", want.window_index, result_ch.window_index);
          check_field("sample_count", want.sample_count, result_ch.sample_count);
          check_field("minimum", want.minimum, result_ch.minimum);
          check_field("maximum", want.maximum, result_ch.maximum);
          check_field("span", want.span, result_ch.span);
          check_field("mean", $signed(want.mean), $signed(result_ch.mean));
          check_field("rms", want.rms, result_ch.rms);
        end
      end
      if (sample_ch.valid && sample_ch.ready) accumulate_sample(sample_ch.sample);
      sample_accepted <= sample_ch.valid && sample_ch.ready;
    end
  end

  // sender holds off until every queued sample is in and every window is out
  task automatic settle();
    while (samples_pending.size() != 0 || sample_ch.valid || stats_due.size() != 0)
      @(posedge clk);
  endtask

  // length register is only touched while the meter is quiet
  task automatic reconfigure(input logic [15:0] length);
    settle();
    repeat (SettleCycles) @(posedge clk);
    @(negedge clk);
    cfg_write <= 1'b1;
    cfg_data  <= length;
    @(negedge clk);
    cfg_write <= 1'b0;
    window_length = length;
  endtask

  function automatic logic [15:0] pick_sample(int style);
    if (style == StyleRailHeavy) begin
      // mostly the bottom rail so the square total runs near its top
      return ($urandom_range(7, 0) == 0) ? 16'hFFFF : 16'h0000;
    end
    case ($urandom_range(9, 0))
      0: return 16'h0000;
      1: return 16'hFFFF;
      2: return Midscale + 16'($urandom_range(8, 0)) - 16'd4;
      default: return 16'($urandom());
    endcase
  endfunction

  task automatic queue_samples(input int count, input int style);
    for (int i = 0; i < count; i++) samples_pending.push_back(pick_sample(style));
  endtask

  function automatic logic [15:0] pick_length();
    case ($urandom_range(19, 0))
      0: return 16'd0;
      1: return 16'd1;
      2: return LengthMax;
      3: return 16'($urandom_range(400, 100));
      default: return 16'($urandom_range(12, 2));
    endcase
  endfunction

  // the stimulus plan
  initial begin
    int pushed;
    int seg;
    int burst;
    clk = 1'b0;
    rst = 1'b1;
    cfg_write = 1'b0;
    cfg_data = '0;
    sample_ch.valid = 1'b0;
    sample_ch.sample = '0;
    result_ch.ready = 1'b0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    mismatch_count = 0;
    window_length = awls_pkg::WINDOW_RESET;
    windows_closed = '0;
    clear_window_totals();

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // untouched register: the reset length is long, so these samples stay in
    // one open window, opened with rail and midscale neighbors
    samples_pending.push_back(16'h0000);
    samples_pending.push_back(16'hFFFF);
    samples_pending.push_back(Midscale);
    samples_pending.push_back(Midscale - 16'd1);
    samples_pending.push_back(16'h0001);
    samples_pending.push_back(16'hFFFE);
    samples_pending.push_back(16'h5555);
    samples_pending.push_back(16'hAAAA);
    queue_samples(32, StyleMixed);

    // zero length acts as one: the open window closes on the next sample,
    // then every sample closes a window
    reconfigure(16'd0);
    samples_pending.push_back(16'h0000);
    samples_pending.push_back(16'hFFFF);
    samples_pending.push_back(Midscale);

    // mean truncates toward zero on both signs: -5/3 gives -1, 5/3 gives 1
    reconfigure(16'd3);
    samples_pending.push_back(Midscale - 16'd2);
    samples_pending.push_back(Midscale - 16'd2);
    samples_pending.push_back(Midscale - 16'd1);
    samples_pending.push_back(Midscale + 16'd2);
    samples_pending.push_back(Midscale + 16'd2);
    samples_pending.push_back(Midscale + 16'd1);

    // length lowered below the running count: next sample closes with count 6
    reconfigure(16'd10);
    queue_samples(5, StyleMixed);
    reconfigure(16'd2);
    queue_samples(1, StyleMixed);

    // length raised mid-window keeps the running totals
    reconfigure(16'd4);
    queue_samples(2, StyleMixed);
    reconfigure(16'd6);
    queue_samples(4, StyleMixed);

    // single-sample windows at both rails
    reconfigure(16'd1);
    samples_pending.push_back(16'hFFFF);
    samples_pending.push_back(16'h0000);

    // random part: lengths and idling change between bursts, partial windows
    // carry across the writes
    pushed = 0;
    seg = 0;
    while (pushed < 1280) begin
      reconfigure(pick_length());
      case (seg % 5)
        1: begin
          send_idle_pct = 66;
          recv_stall_pct = 0;
        end
        2: begin
          send_idle_pct = 0;
          recv_stall_pct = 66;
        end
        3: begin
          send_idle_pct = 32;
          recv_stall_pct = 32;
        end
        default: begin
          send_idle_pct = 0;
          recv_stall_pct = 0;
        end
      endcase
      burst = $urandom_range(90, 40);
      if (seg % 4 == 1) begin
        // hold the sender mid-burst until every window has come out
        queue_samples(burst / 2, StyleMixed);
        settle();
        queue_samples(burst - burst / 2, StyleMixed);
      end else begin
        queue_samples(burst, StyleMixed);
      end
      pushed += burst;
      seg++;
    end

    // rail-heavy windows so the sum and square totals see their extremes
    reconfigure(16'd40);
    send_idle_pct = 0;
    recv_stall_pct = 0;
    queue_samples(80, StyleRailHeavy);

    settle();
    repeat (SettleCycles) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  // hang guard, far beyond the slowest legal run
  initial begin
    #25_000_000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule

// ===== files.f =====
design/awls_pkg.sv
design/awls_sample_if.sv
design/awls_result_if.sv
design/awls_front.sv
design/awls_queue.sv
design/awls_back.sv
design/audio_window_level_stats_top.sv
bench/audio_window_level_stats_top_tb.sv
